// ===== design/rki_pkg.sv =====
// Package for the RGB keyframe interpolator.
// Holds the command codes, the sequencer states, the table entry type and sizes.
// No dependencies.
`default_nettype none

package rki_pkg;

    // Default number of table entries and the largest table the 4-bit index reaches
    localparam int PHASES_DEFAULT = 16;
    localparam int TABLE_MAX      = 16;

    // Command codes of an input item
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_SAMPLE  = 2'd2;

    // Bit-serial multiply and divide run over one color channel
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int TIME_W    = 16;
    localparam int PROD_W    = CHAN_W + TIME_W;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_RD_NXT,
        S_DECIDE,
        S_LOAD,
        S_MUL,
        S_DIVINIT,
        S_DIV,
        S_STORE,
        S_OUT
    } rki_state_t;

    // One phase table entry
    typedef struct packed {
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] trans;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } tbl_entry_t;

endpackage

`default_nettype wire

// ===== design/rgb_keyframe_interpolator_top.sv =====
// RGB keyframe interpolator: phase table, sequencer and bit-serial multiply/divide.
// Depends on rki_pkg.
`default_nettype none

// Usage
// - Input channel (s_valid/s_ready) carries write, restart and time-sample items.
//   A write item loads one phase table entry, a restart item sets the phase start
//   time to s_now_ms and selects phase 0; neither gives a result.
// - Every time-sample item gives exactly one result item on the m_ channel with
//   the current color, the phase in force and whether the phase advanced.
// - A sample with a phase count of zero goes straight to the output state; else
//   both entries are read, in the hold or past the transition the result then
//   loads; inside a transition the shared unit does per channel a load step, an
//   8-step shift-add multiply, a setup, an 8-step restoring divide and a store.
// - One item is worked on at a time; s_ready is high while the sequencer is idle,
//   so a sample holds off the input until its result is loaded for output.
// - The result sits in an output register; while the receiver stalls the next
//   item is still accepted and worked on, and the sequencer waits only when a
//   second result is ready before the first was taken.
// - cfg_wr_en/cfg_wr_data write the phase count; write it only while idle.
// - Reset (aresetn low, synchronous) clears phase, start time, color, phase
//   count and the output valid. The phase table is not cleared.

module rgb_keyframe_interpolator_top
    import rki_pkg::*;
#(
    parameter int PHASES = PHASES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    // Input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [3:0]  s_entry_index,
    input  wire logic [15:0] s_hold_ms,
    input  wire logic [15:0] s_transition_ms,
    input  wire logic [7:0]  s_red_in,
    input  wire logic [7:0]  s_green_in,
    input  wire logic [7:0]  s_blue_in,
    input  wire logic [31:0] s_now_ms,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red_out,
    output logic [7:0]       m_green_out,
    output logic [7:0]       m_blue_out,
    output logic [3:0]       m_phase_now,
    output logic             m_advanced
);

    localparam int TBL_DEPTH = (PHASES < TABLE_MAX) ? PHASES : TABLE_MAX;
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // Sequencer
    rki_state_t state_reg, state_next;

    // Architectural state
    logic [4:0]        phase_count_reg;
    logic [IDX_W-1:0]  phase_reg;
    logic [31:0]       start_reg;
    logic [CHAN_W-1:0] color_reg [NUM_CHAN];

    // Phase table
    tbl_entry_t        tbl_mem [TBL_DEPTH];
    tbl_entry_t        rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;

    // Per-sample working registers
    logic [31:0]       now_reg;
    logic [31:0]       elapsed_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  nxt_reg;
    logic [TIME_W-1:0] cur_hold_reg;
    logic [TIME_W-1:0] cur_trans_reg;
    logic [CHAN_W-1:0] cur_rgb_reg [NUM_CHAN];
    logic [CHAN_W-1:0] nxt_rgb_reg [NUM_CHAN];
    logic [TIME_W-1:0] part_reg;
    logic              adv_reg;

    // Shared multiply/divide unit
    logic [1:0]        ch_reg;
    logic [2:0]        cnt_reg;
    logic [CHAN_W-1:0] from_reg;
    logic              neg_reg;
    logic [CHAN_W-1:0] mag_reg;
    logic [CHAN_W-1:0] mplier_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [CHAN_W-1:0] qsh_reg;

    // Output register
    logic              m_valid_reg;
    logic [CHAN_W-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic [3:0]        m_phase_reg;
    logic              m_adv_reg;

    // Control decoded from state
    logic              accept;
    logic              tbl_we;
    logic              out_load;

    // Decode of a sample at accept time
    logic [4:0]        n_use;
    logic [IDX_W-1:0]  cur_sel;
    logic [IDX_W-1:0]  nxt_sel;

    // Decision terms
    logic [TIME_W:0]   hold_sum;
    logic              in_hold;
    logic              in_trans;
    logic [31:0]       part_full;

    // Channel setup terms
    logic [CHAN_W:0]   delta;
    logic [CHAN_W-1:0] mag;
    logic [CHAN_W-1:0] from_sel;
    logic [CHAN_W-1:0] to_sel;

    // Divide step terms
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   trial_sub;
    logic              qbit;

    // Count in use and current/next phase
    always_comb begin
        n_use = (phase_count_reg > 5'(TBL_DEPTH)) ? 5'(TBL_DEPTH) : phase_count_reg;
        cur_sel = (5'(phase_reg) < n_use) ? phase_reg : '0;
        nxt_sel = (5'(cur_sel) + 5'd1 == n_use) ? '0 : IDX_W'(5'(cur_sel) + 5'd1);
    end

    // Compare elapsed time against hold and hold plus transition
    always_comb begin
        hold_sum  = {1'b0, cur_hold_reg} + {1'b0, cur_trans_reg};
        in_hold   = elapsed_reg[31] || (elapsed_reg < 32'(cur_hold_reg));
        in_trans  = elapsed_reg < 32'(hold_sum);
        part_full = elapsed_reg - 32'(cur_hold_reg);
    end

    // Select the channel pair and take the magnitude of the step
    always_comb begin
        from_sel = cur_rgb_reg[ch_reg];
        to_sel   = nxt_rgb_reg[ch_reg];
        delta    = {1'b0, to_sel} - {1'b0, from_sel};
        mag      = delta[CHAN_W] ? CHAN_W'(-delta) : delta[CHAN_W-1:0];
    end

    // One restoring divide step
    always_comb begin
        trial     = {rem_reg, qsh_reg[CHAN_W-1]};
        trial_sub = trial - {1'b0, cur_trans_reg};
        qbit      = trial >= {1'b0, cur_trans_reg};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_cmd == CMD_SAMPLE) begin
                    state_next = (n_use == 5'd0) ? S_OUT : S_RD_CUR;
                end
            end
            S_RD_CUR:  state_next = S_RD_NXT;
            S_RD_NXT:  state_next = S_DECIDE;
            S_DECIDE: begin
                if (!in_hold && in_trans) begin
                    state_next = S_LOAD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_LOAD:    state_next = S_MUL;
            S_MUL:     state_next = (cnt_reg == 3'd7) ? S_DIVINIT : S_MUL;
            S_DIVINIT: state_next = S_DIV;
            S_DIV:     state_next = (cnt_reg == 3'd7) ? S_STORE : S_DIV;
            S_STORE:   state_next = (ch_reg == 2'(NUM_CHAN - 1)) ? S_OUT : S_LOAD;
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        rd_addr  = cur_reg;
        unique case (state_reg)
            S_IDLE:   s_ready  = 1'b1;
            S_RD_NXT: rd_addr  = nxt_reg;
            S_OUT:    out_load = !m_valid_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
            end
        endcase
        accept = s_valid && s_ready;
        tbl_we = accept && s_cmd == CMD_WRITE && ({1'b0, s_entry_index} < 5'(TBL_DEPTH));
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Phase table write and registered read
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[s_entry_index[IDX_W-1:0]] <= '{hold:  s_hold_ms,
                                                   trans: s_transition_ms,
                                                   red:   s_red_in,
                                                   green: s_green_in,
                                                   blue:  s_blue_in};
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg <= '0;
        end else if (cfg_wr_en) begin
            phase_count_reg <= cfg_wr_data;
        end
    end

    // Architectural state: phase, start time and color
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            start_reg <= '0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                color_reg[i] <= '0;
            end
        end else begin
            if (accept && s_cmd == CMD_RESTART) begin
                start_reg <= s_now_ms;
                phase_reg <= '0;
            end
            if (state_reg == S_DECIDE) begin
                if (in_hold) begin
                    phase_reg    <= cur_reg;
                    color_reg[0] <= cur_rgb_reg[0];
                    color_reg[1] <= cur_rgb_reg[1];
                    color_reg[2] <= cur_rgb_reg[2];
                end else if (in_trans) begin
                    phase_reg <= cur_reg;
                end else begin
                    phase_reg <= nxt_reg;
                    start_reg <= start_reg + 32'(hold_sum);
                end
            end
            if (state_reg == S_STORE) begin
                color_reg[ch_reg] <= neg_reg ? from_reg - qsh_reg : from_reg + qsh_reg;
            end
        end
    end

    // Per-sample working registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && accept) begin
            now_reg <= s_now_ms;
            cur_reg <= cur_sel;
            nxt_reg <= nxt_sel;
            adv_reg <= 1'b0;
        end
        if (state_reg == S_RD_NXT) begin
            cur_hold_reg   <= rd_data_reg.hold;
            cur_trans_reg  <= rd_data_reg.trans;
            cur_rgb_reg[0] <= rd_data_reg.red;
            cur_rgb_reg[1] <= rd_data_reg.green;
            cur_rgb_reg[2] <= rd_data_reg.blue;
            elapsed_reg    <= now_reg - start_reg;
        end
        if (state_reg == S_DECIDE) begin
            nxt_rgb_reg[0] <= rd_data_reg.red;
            nxt_rgb_reg[1] <= rd_data_reg.green;
            nxt_rgb_reg[2] <= rd_data_reg.blue;
            part_reg       <= part_full[TIME_W-1:0];
            adv_reg        <= !in_hold && !in_trans;
        end
    end

    // Shared shift-add multiply and restoring divide, one bit per cycle
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_DECIDE: begin
                ch_reg <= '0;
            end
            S_LOAD: begin
                from_reg   <= from_sel;
                neg_reg    <= delta[CHAN_W];
                mag_reg    <= mag;
                mplier_reg <= mag;
                mcand_reg  <= PROD_W'(part_reg);
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            S_MUL: begin
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 3'd1;
            end
            S_DIVINIT: begin
                rem_reg <= acc_reg[PROD_W-1:CHAN_W];
                qsh_reg <= acc_reg[CHAN_W-1:0];
                cnt_reg <= '0;
            end
            S_DIV: begin
                rem_reg <= qbit ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
                qsh_reg <= {qsh_reg[CHAN_W-2:0], qbit};
                cnt_reg <= cnt_reg + 3'd1;
            end
            S_STORE: begin
                ch_reg <= ch_reg + 2'd1;
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Output register: load a finished item, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_red_reg   <= color_reg[0];
            m_green_reg <= color_reg[1];
            m_blue_reg  <= color_reg[2];
            m_phase_reg <= 4'(phase_reg);
            m_adv_reg   <= adv_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_red_reg;
    assign m_green_out = m_green_reg;
    assign m_blue_out  = m_blue_reg;
    assign m_phase_now = m_phase_reg;
    assign m_advanced  = m_adv_reg;

    // The partial remainder stays below the divisor through every divide step
    a_rem_below_trans: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < cur_trans_reg))
        else $error("divide remainder not below transition time");

    // A quotient never exceeds the step magnitude, so the color cannot overshoot
    a_quot_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STORE) |-> (qsh_reg <= mag_reg))
        else $error("interpolation quotient exceeds channel step");

    // A new result appears only out of the output state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output state");

endmodule

`default_nettype wire
